/* rtl/kfpr_pkg.sv */
package kfpr_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int COUNT_W    = SLOT_W + 1;
  localparam int REC_W      = 64 + 24 + 1;

  localparam logic [10:0] FRAME_LIMIT_RST = 11'd900;
  localparam logic [39:0] DURATION_RST    = 40'd30000000;
  localparam logic [19:0] USEC_PER_SEC    = 20'd1000000;
  localparam logic [10:0] USEC_PER_MSEC   = 11'd1000;
  // Ceiling of 2^36 / 1000; exact for dividends below 2^26.
  localparam logic [26:0] MSEC_RECIP      = 27'd68719477;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_STATS   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic {
    CFG_FRAME_LIMIT = 1'b0,
    CFG_DURATION    = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EV_FULL  = 2'd0,
    EV_COUNT = 2'd1,
    EV_DUR   = 2'd2
  } ev_phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EV_RD,
    ST_EV_CHK,
    ST_WRITE,
    ST_ST_RD,
    ST_ST_CHK,
    ST_EX_MUL,
    ST_EX_TGT,
    ST_EX_RD,
    ST_EX_CHK,
    ST_BK_RD,
    ST_BK_CHK,
    ST_DIV_INIT,
    ST_DIV_Q,
    ST_DIV_R,
    ST_FIN
  } state_t;

endpackage

/* rtl/keyframe_preroll_descriptor_ring_top.sv */
// Descriptor ring for pre-event recording of encoded frames.
// The input channel (in_valid, in_stall) carries one item per request: op selects
// push, extract, stats or clear, with the frame fields and window used as the op needs.
// The output channel (out_valid, out_stall) returns exactly one result item per item.
// The config channel (cfg_valid, cfg_ready) writes frame_limit (index 0) and
// duration_limit_us (index 1); it is always ready. The user must write it only while
// idle; the block itself does not enforce this. One item is worked at a time; in_stall
// is high from acceptance until the result is loaded into the output register.
// Descriptors live in a single-port-read RAM, so every access to a stored entry takes
// a read state and a check state of the sequencer. A stats item reads the oldest entry
// and divides the span by 1000 in four 16-bit digits by reciprocal multiplication.
// A push evicts the oldest frame if the ring is full, writes the frame, evicts by
// frame limit and then by duration, then divides the span if frames are left held.
// An extract runs a forward scan to the window's target time and then a backward
// keyframe walk over the RAM read port. Empty extracts, empty stats and clears go
// straight to the result load; the next item is accepted in the cycle after the
// result load. Reset empties the ring and restores the register defaults; stored
// entries are not cleared since they are read only inside the held range. While the
// receiver stalls, the result stays in the output register and the block may accept
// and work the next item, holding its result until the slot frees.
module keyframe_preroll_descriptor_ring_top import kfpr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   op,
  input  logic [63:0]  frame_timestamp_us,
  input  logic [23:0]  frame_bytes,
  input  logic         frame_is_keyframe,
  input  logic [15:0]  window_seconds,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         found,
  output logic [9:0]   start_slot,
  output logic [10:0]  frame_tally,
  output logic [33:0]  byte_total,
  output logic [63:0]  oldest_timestamp_us,
  output logic [63:0]  newest_timestamp_us,
  output logic [54:0]  span_ms,
  output logic [10:0]  evicted_count,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [39:0]  cfg_data
);

  state_t state, state_next;

  logic [10:0]        frame_limit;
  logic [39:0]        duration_limit_us;
  logic [SLOT_W-1:0]  oldest_slot;
  logic [COUNT_W-1:0] held_count;
  logic [33:0]        running_bytes;
  logic [63:0]        latest_ts;
  logic [63:0]        oldest_ts;

  op_t                op_q;
  logic [63:0]        ts_q;
  logic [23:0]        bytes_q;
  logic               kf_q;
  logic [15:0]        win_q;

  ev_phase_t          phase;
  logic [10:0]        ev_cnt;
  logic [35:0]        cutoff;
  logic [63:0]        target;
  logic [SLOT_W-1:0]  scan_k;
  logic [SLOT_W-1:0]  back_i;
  logic               found_w;
  logic [SLOT_W-1:0]  start_w;
  logic [COUNT_W-1:0] count_w;
  logic [63:0]        div_q;
  logic [9:0]         div_r;
  logic [15:0]        div_digit;
  logic [1:0]         div_cnt;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [SLOT_W-1:0]  ram_raddr;
  logic [REC_W-1:0]   ram_rdata;
  logic [63:0]        rd_ts;
  logic [23:0]        rd_size;
  logic               rd_kf;

  logic [COUNT_W-1:0] eff_limit;
  logic               drop;
  logic [25:0]        div_v;
  logic [52:0]        div_prod;
  logic [25:0]        div_rem;
  logic               in_accept;
  logic               out_load;
  logic               scan_last;

  assign rd_ts   = ram_rdata[63:0];
  assign rd_size = ram_rdata[87:64];
  assign rd_kf   = ram_rdata[88];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == ST_FIN) && (!out_valid || !out_stall);

  assign eff_limit = (frame_limit > 11'(RING_DEPTH)) ? COUNT_W'(RING_DEPTH)
                                                     : COUNT_W'(frame_limit);
  assign scan_last = ({1'b0, scan_k} == held_count - COUNT_W'(1));
  assign div_v     = {div_r, div_q[63:48]};
  assign div_prod  = 53'(div_v) * 53'(MSEC_RECIP);
  assign div_rem   = div_v - 26'(div_digit) * 26'(USEC_PER_MSEC);

  always_comb begin
    unique case (phase)
      EV_FULL:  drop = 1'b1;
      EV_COUNT: drop = (held_count > eff_limit);
      EV_DUR:   drop = (held_count != '0) &&
                       ((latest_ts - rd_ts) > {24'd0, duration_limit_us});
      default:  drop = 1'b0;
    endcase
  end

  kfpr_ram #(
    .WIDTH(REC_W),
    .DEPTH(RING_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data ({kf_q, bytes_q, ts_q}),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = oldest_slot + held_count[SLOT_W-1:0];
    ram_raddr  = oldest_slot;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (op_t'(op))
            OP_PUSH:    state_next = (held_count == COUNT_W'(RING_DEPTH)) ? ST_EV_RD
                                                                          : ST_WRITE;
            OP_EXTRACT: state_next = (held_count == '0) ? ST_FIN : ST_EX_MUL;
            OP_STATS:   state_next = (held_count == '0) ? ST_FIN : ST_ST_RD;
            OP_CLEAR:   state_next = ST_FIN;
            default:    state_next = ST_FIN;
          endcase
        end
      end
      ST_EV_RD: state_next = ST_EV_CHK;
      ST_EV_CHK: begin
        if (drop) begin
          state_next = (phase == EV_FULL) ? ST_WRITE : ST_EV_RD;
        end else if (phase == EV_COUNT) begin
          state_next = ST_EV_RD;
        end else begin
          state_next = (held_count == '0) ? ST_FIN : ST_DIV_INIT;
        end
      end
      ST_WRITE: begin
        ram_we     = 1'b1;
        state_next = ST_EV_RD;
      end
      ST_ST_RD:  state_next = ST_ST_CHK;
      ST_ST_CHK: state_next = ST_DIV_INIT;
      ST_EX_MUL: state_next = ST_EX_TGT;
      ST_EX_TGT: state_next = ST_EX_RD;
      ST_EX_RD: begin
        ram_raddr  = oldest_slot + scan_k;
        state_next = ST_EX_CHK;
      end
      ST_EX_CHK: begin
        ram_raddr  = oldest_slot + scan_k;
        state_next = (rd_ts >= target || scan_last) ? ST_BK_RD : ST_EX_RD;
      end
      ST_BK_RD: begin
        ram_raddr  = oldest_slot + back_i;
        state_next = ST_BK_CHK;
      end
      ST_BK_CHK: begin
        ram_raddr  = oldest_slot + back_i;
        state_next = (back_i != '0 && !rd_kf) ? ST_BK_RD : ST_FIN;
      end
      ST_DIV_INIT: state_next = ST_DIV_Q;
      ST_DIV_Q:    state_next = ST_DIV_R;
      ST_DIV_R:    state_next = (div_cnt == 2'd3) ? ST_FIN : ST_DIV_Q;
      ST_FIN:      state_next = out_load ? ST_IDLE : ST_FIN;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit       <= FRAME_LIMIT_RST;
      duration_limit_us <= DURATION_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_LIMIT: frame_limit       <= cfg_data[10:0];
        CFG_DURATION:    duration_limit_us <= cfg_data;
        default:         frame_limit       <= frame_limit;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_slot   <= '0;
      held_count    <= '0;
      running_bytes <= '0;
    end else begin
      if (state == ST_IDLE && in_accept && op_t'(op) == OP_CLEAR) begin
        oldest_slot   <= '0;
        held_count    <= '0;
        running_bytes <= '0;
      end else if (state == ST_WRITE) begin
        held_count    <= held_count + COUNT_W'(1);
        running_bytes <= running_bytes + 34'(bytes_q);
      end else if (state == ST_EV_CHK && drop) begin
        oldest_slot   <= oldest_slot + SLOT_W'(1);
        held_count    <= held_count - COUNT_W'(1);
        running_bytes <= running_bytes - 34'(rd_size);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          op_q    <= op_t'(op);
          ts_q    <= frame_timestamp_us;
          bytes_q <= frame_bytes;
          kf_q    <= frame_is_keyframe;
          win_q   <= window_seconds;
          ev_cnt  <= '0;
          found_w <= 1'b0;
          start_w <= '0;
          count_w <= '0;
          phase   <= (held_count == COUNT_W'(RING_DEPTH)) ? EV_FULL : EV_COUNT;
        end
      end
      ST_EV_CHK: begin
        if (drop) begin
          ev_cnt <= ev_cnt + 11'd1;
        end else if (phase == EV_COUNT) begin
          phase <= EV_DUR;
        end else begin
          oldest_ts <= rd_ts;
        end
      end
      ST_WRITE: begin
        latest_ts <= ts_q;
        phase     <= EV_COUNT;
      end
      ST_ST_CHK: oldest_ts <= rd_ts;
      ST_EX_MUL: cutoff <= 36'(win_q) * 36'(USEC_PER_SEC);
      ST_EX_TGT: begin
        target <= (latest_ts > {28'd0, cutoff}) ? latest_ts - {28'd0, cutoff} : '0;
        scan_k <= '0;
      end
      ST_EX_CHK: begin
        if (rd_ts >= target || scan_last) begin
          back_i <= scan_k;
        end else begin
          scan_k <= scan_k + SLOT_W'(1);
        end
      end
      ST_BK_CHK: begin
        if (back_i != '0 && !rd_kf) begin
          back_i <= back_i - SLOT_W'(1);
        end else begin
          found_w <= 1'b1;
          start_w <= oldest_slot + back_i;
          count_w <= held_count - {1'b0, back_i};
        end
      end
      ST_DIV_INIT: begin
        div_q   <= latest_ts - oldest_ts;
        div_r   <= '0;
        div_cnt <= '0;
      end
      ST_DIV_Q: div_digit <= div_prod[51:36];
      ST_DIV_R: begin
        div_r   <= div_rem[9:0];
        div_q   <= {div_q[47:0], div_digit};
        div_cnt <= div_cnt + 2'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (op_q == OP_EXTRACT) begin
        found               <= found_w;
        start_slot          <= start_w;
        frame_tally         <= count_w;
        byte_total          <= '0;
        oldest_timestamp_us <= '0;
        newest_timestamp_us <= '0;
        span_ms             <= '0;
        evicted_count       <= '0;
      end else begin
        found               <= 1'b0;
        start_slot          <= '0;
        frame_tally         <= held_count;
        byte_total          <= running_bytes;
        oldest_timestamp_us <= (held_count != '0) ? oldest_ts : '0;
        newest_timestamp_us <= (held_count != '0) ? latest_ts : '0;
        span_ms             <= (held_count != '0) ? div_q[54:0] : '0;
        evicted_count       <= (op_q == OP_PUSH) ? ev_cnt : '0;
      end
    end
  end

endmodule

/* rtl/kfpr_ram.sv */
module kfpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* test/tb_top.sv */
module tb_top;
  import kfpr_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  op;
  logic [63:0] frame_timestamp_us;
  logic [23:0] frame_bytes;
  logic        frame_is_keyframe;
  logic [15:0] window_seconds;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found;
  logic [9:0]  start_slot;
  logic [10:0] frame_tally;
  logic [33:0] byte_total;
  logic [63:0] oldest_timestamp_us;
  logic [63:0] newest_timestamp_us;
  logic [54:0] span_ms;
  logic [10:0] evicted_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [39:0] cfg_data;

  localparam int IDLE_LIMIT = 60000;

  typedef struct packed {
    logic        found;
    logic [9:0]  start_slot;
    logic [10:0] frame_tally;
    logic [33:0] byte_total;
    logic [63:0] oldest_ts;
    logic [63:0] latest_ts;
    logic [54:0] span_ms;
    logic [10:0] evicted;
  } ring_res_t;

  class ring_scoreboard;
    logic [63:0] ts_mem[RING_DEPTH];
    logic [23:0] size_mem[RING_DEPTH];
    logic        key_mem[RING_DEPTH];
    int          oldest;
    int          held;
    logic [33:0] bytes;
    logic [10:0] frame_limit;
    logic [39:0] duration_limit;
    ring_res_t   expected_q[$];
    int          errors;

    function new();
      oldest = 0;
      held = 0;
      bytes = '0;
      frame_limit = FRAME_LIMIT_RST;
      duration_limit = DURATION_RST;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_register(cfg_idx_t idx, logic [39:0] value);
      if (idx == CFG_FRAME_LIMIT) frame_limit = value[10:0];
      else duration_limit = value;
    endfunction

    function int slot(int k);
      return (oldest + k) % RING_DEPTH;
    endfunction

    function void drop_oldest();
      bytes = bytes - {10'b0, size_mem[oldest]};
      oldest = slot(1);
      held--;
    endfunction

    function void fill_occupancy(ref ring_res_t r);
      logic [63:0] o;
      logic [63:0] n;
      logic [63:0] d;
      r.frame_tally = held[10:0];
      r.byte_total = bytes;
      if (held > 0) begin
        o = ts_mem[oldest];
        n = ts_mem[slot(held - 1)];
        d = (n - o) / 64'd1000;
        r.oldest_ts = o;
        r.latest_ts = n;
        r.span_ms = d[54:0];
      end
    endfunction

    function void note_item(op_t o, logic [63:0] t, logic [23:0] b, logic k,
                            logic [15:0] w);
      ring_res_t   r;
      int          ev;
      int          lim;
      int          s;
      int          i;
      logic [63:0] newest;
      logic [63:0] cutoff;
      logic [63:0] target;
      r = '0;
      case (o)
        OP_PUSH: begin
          ev = 0;
          lim = (frame_limit < RING_DEPTH) ? int'(frame_limit) : RING_DEPTH;
          if (held >= RING_DEPTH) begin
            drop_oldest();
            ev++;
          end
          s = slot(held);
          ts_mem[s] = t;
          size_mem[s] = b;
          key_mem[s] = k;
          bytes = bytes + {10'b0, b};
          held++;
          while (held > lim) begin
            drop_oldest();
            ev++;
          end
          if (held > 0) begin
            newest = ts_mem[slot(held - 1)];
            while (held > 0 && (newest - ts_mem[oldest]) > {24'b0, duration_limit}) begin
              drop_oldest();
              ev++;
            end
          end
          fill_occupancy(r);
          r.evicted = ev[10:0];
        end
        OP_EXTRACT: begin
          if (held > 0) begin
            cutoff = 64'(w) * 64'd1000000;
            newest = ts_mem[slot(held - 1)];
            target = (newest > cutoff) ? newest - cutoff : 64'd0;
            i = held - 1;
            for (int j = 0; j < held; j++) begin
              if (ts_mem[slot(j)] >= target) begin
                i = j;
                break;
              end
            end
            while (i > 0 && !key_mem[slot(i)]) i--;
            r.found = 1'b1;
            r.start_slot = 10'(slot(i));
            r.frame_tally = 11'(held - i);
          end
        end
        OP_STATS: fill_occupancy(r);
        default: begin
          oldest = 0;
          held = 0;
          bytes = '0;
          fill_occupancy(r);
        end
      endcase
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(ring_res_t got);
      ring_res_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: %h", $time, got);
        errors++;
        return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      if (got.found !== e.found) begin
        $display("%0t: found exp %0d got %0d", $time, e.found, got.found);
        errors++;
      end
      if (got.start_slot !== e.start_slot) begin
        $display("%0t: start_slot exp %0d got %0d", $time, e.start_slot, got.start_slot);
        errors++;
      end
      if (got.frame_tally !== e.frame_tally) begin
        $display("%0t: frame_tally exp %0d got %0d", $time, e.frame_tally, got.frame_tally);
        errors++;
      end
      if (got.byte_total !== e.byte_total) begin
        $display("%0t: byte_total exp %0d got %0d", $time, e.byte_total, got.byte_total);
        errors++;
      end
      if (got.oldest_ts !== e.oldest_ts) begin
        $display("%0t: oldest_ts exp %0d got %0d", $time, e.oldest_ts, got.oldest_ts);
        errors++;
      end
      if (got.latest_ts !== e.latest_ts) begin
        $display("%0t: latest_ts exp %0d got %0d", $time, e.latest_ts, got.latest_ts);
        errors++;
      end
      if (got.span_ms !== e.span_ms) begin
        $display("%0t: span_ms exp %0d got %0d", $time, e.span_ms, got.span_ms);
        errors++;
      end
      if (got.evicted !== e.evicted) begin
        $display("%0t: evicted exp %0d got %0d", $time, e.evicted, got.evicted);
        errors++;
      end
    endfunction
  endclass

  ring_scoreboard sb;
  logic        quiet;
  logic        hold_req;
  logic        hold_done = 1'b0;
  int          idle_cycles;
  int unsigned stall_len;
  logic        stall_val;
  logic [63:0] cur_ts;

  keyframe_preroll_descriptor_ring_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_item(op_t'(op), frame_timestamp_us, frame_bytes, frame_is_keyframe,
                     window_seconds);
      if (out_valid && !out_stall)
        sb.check_result({found, start_slot, frame_tally, byte_total, oldest_timestamp_us,
                         newest_timestamp_us, span_ms, evicted_count});
      if (cfg_valid && cfg_ready) sb.set_register(cfg_idx_t'(cfg_index), cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver holds off for a long stretch on request, otherwise stalls at random.
  always begin
    @(posedge clk);
    if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      repeat (2000) @(posedge clk);
      hold_done = 1'b1;
      out_stall <= 1'b0;
    end else begin
      stall_val = !quiet && ($urandom_range(0, 2) == 0);
      stall_len = gap_len();
      out_stall <= stall_val;
      repeat (stall_len) @(posedge clk);
    end
  end

  task automatic send_item(op_t o, logic [63:0] t, logic [23:0] b, logic k,
                           logic [15:0] w);
    int unsigned g;
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    frame_timestamp_us <= t;
    frame_bytes <= b;
    frame_is_keyframe <= k;
    window_seconds <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [39:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_frame();
    int unsigned r;
    logic [23:0] b;
    r = $urandom_range(0, 99);
    if (r < 85) cur_ts = cur_ts + 64'($urandom_range(30000, 36000));
    else if (r < 92) cur_ts = cur_ts + 64'($urandom_range(1000000, 60000000));
    else if (r < 97) cur_ts = cur_ts - 64'($urandom_range(1, 5000000));
    else cur_ts = {$urandom, $urandom};
    r = $urandom_range(0, 19);
    b = (r == 0) ? 24'hFFFFFF : (r == 1) ? 24'd0 : 24'($urandom);
    send_item(OP_PUSH, cur_ts, b, $urandom_range(0, 7) == 0, 16'($urandom));
  endtask

  task automatic random_item();
    int unsigned r;
    logic [15:0] w;
    r = $urandom_range(0, 99);
    w = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    if (r < 68) push_frame();
    else if (r < 85) send_item(OP_EXTRACT, {$urandom, $urandom}, 24'($urandom), 1'($urandom), w);
    else if (r < 96) send_item(OP_STATS, {$urandom, $urandom}, 24'($urandom), 1'($urandom), w);
    else send_item(OP_CLEAR, {$urandom, $urandom}, 24'($urandom), 1'($urandom), w);
  endtask

  logic [10:0] lim_set[7] = '{11'd0, 11'd1, 11'd2047, 11'd16, 11'd5, 11'd40, 11'd900};
  logic [39:0] dur_set[7] = '{40'd1000, 40'hFFFFFFFFFF, 40'hFFFFFFFFFF, 40'd500000,
                              40'd0, 40'd2000000, 40'd30000000};

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_PUSH;
    frame_timestamp_us = '0;
    frame_bytes = '0;
    frame_is_keyframe = 1'b0;
    window_seconds = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FRAME_LIMIT;
    cfg_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    cur_ts = 64'd1000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(OP_EXTRACT, '0, '0, 1'b0, 16'd0);
    send_item(OP_STATS, '1, '1, 1'b1, 16'hFFFF);
    send_item(OP_CLEAR, '0, '0, 1'b0, 16'd0);
    send_item(OP_PUSH, 64'd0, 24'd0, 1'b0, 16'd0);
    send_item(OP_PUSH, 64'd100, 24'hFFFFFF, 1'b1, 16'd0);
    send_item(OP_PUSH, 64'd2000000, 24'd5, 1'b0, 16'd0);
    send_item(OP_EXTRACT, '0, '0, 1'b0, 16'd0);
    send_item(OP_EXTRACT, '0, '0, 1'b0, 16'hFFFF);
    send_item(OP_EXTRACT, '0, '0, 1'b0, 16'd1);
    send_item(OP_PUSH, 64'd50, 24'd7, 1'b1, 16'd0);
    send_item(OP_STATS, '0, '0, 1'b0, 16'd0);
    send_item(OP_PUSH, '1, 24'd9, 1'b0, 16'd0);
    send_item(OP_PUSH, 64'd1, 24'd3, 1'b0, 16'd0);
    send_item(OP_EXTRACT, '0, '0, 1'b0, 16'd0);
    send_item(OP_CLEAR, '1, '1, 1'b1, 16'hFFFF);
    send_item(OP_PUSH, 64'd10, 24'd1, 1'b0, 16'd0);
    send_item(OP_PUSH, 64'd20, 24'd2, 1'b0, 16'd0);
    send_item(OP_PUSH, 64'd30, 24'd3, 1'b0, 16'd0);
    send_item(OP_EXTRACT, '0, '0, 1'b0, 16'd0);
    send_item(OP_STATS, '0, '0, 1'b0, 16'd0);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      write_register(CFG_FRAME_LIMIT, {29'b0, lim_set[p]});
      write_register(CFG_DURATION, dur_set[p]);
      quiet = (p == 3);
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < 36; n++) random_item();
      wait_drained();
    end
    quiet = 1'b0;

    write_register(CFG_FRAME_LIMIT, {29'b0, 11'($urandom)});
    write_register(CFG_DURATION, {$urandom, 8'($urandom)});
    for (int n = 0; n < 20; n++) random_item();
    wait_drained();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
